### sv/bdq_pkg.sv
// Shared types and constants for the bounded deque.
// No dependencies; used by every module of the block but bdq_ram.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Request codes carried in s_tuser
    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ_POS   = 3'd4,
        REQ_COUNT      = 3'd5
    } req_t;

    localparam int REQ_W = 3;
    localparam int CAP_W = 9;
    localparam int CAP_RESET = 256;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // What the back end does with the store for one command
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ok;
    } cmd_ctrl_t;

endpackage

`default_nettype wire

### sv/bdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/bdq_queue.sv
// Short flip-flop FIFO that carries commands from the front end to the back end.
// Depends on bdq_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module bdq_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  not_empty
);

    localparam int QD = bdq_pkg::QUEUE_DEPTH;
    localparam int QI_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    logic [WIDTH-1:0] slot_reg [QD];
    logic [QI_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QI_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  fill_reg, fill_next;
    logic             push, pop;

    assign full      = (fill_reg == QC_W'(QD));
    assign not_empty = (fill_reg != '0);
    assign push      = wr_en && !full;
    assign pop       = rd_en && not_empty;
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QI_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QI_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### sv/bdq_front.sv
// Front end: takes requests, tracks front index, count and capacity, and
// turns each request into a store command. Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_front #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [bdq_pkg::CAP_W-1:0]        cfg_wdata,
    input  wire logic                             req_valid,
    input  wire logic [bdq_pkg::REQ_W-1:0]        req_type,
    input  wire logic [DATA_W-1:0]                req_payload,
    input  wire logic [$clog2(DEPTH+1)-1:0]       req_position,
    output logic                                  req_ready,
    output logic                                  cmd_valid,
    input  wire logic                             cmd_full,
    output bdq_pkg::cmd_ctrl_t                    cmd_ctrl,
    output logic      [$clog2(DEPTH)-1:0]         cmd_addr,
    output logic      [DATA_W-1:0]                cmd_payload,
    output logic      [$clog2(DEPTH+1)-1:0]       cmd_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;

    logic [bdq_pkg::CAP_W-1:0] capacity_reg;
    logic [IDX_W-1:0]          front_reg, front_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      accept, can_push, not_empty, pos_ok;
    logic [CMP_W-1:0]          cnt_ext;
    logic [CNT_W-1:0]          pos_m1;
    logic [IDX_W-1:0]          front_dec, front_inc, idx_back, idx_last, idx_pos;

    // ring index of base plus offset, offset at most DEPTH
    function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
        if (s >= SUM_W'(DEPTH))
        begin
            return IDX_W'(s - SUM_W'(DEPTH));
        end
        return IDX_W'(s);
    endfunction

    assign req_ready = !cmd_full;
    assign accept    = req_valid && !cmd_full;
    assign cmd_valid = accept;

    assign cnt_ext   = CMP_W'(count_reg);
    assign can_push  = (cnt_ext < CMP_W'(capacity_reg)) && (cnt_ext < CMP_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pos_ok    = (req_position != '0) && (req_position <= count_reg);
    assign pos_m1    = req_position - 1'b1;

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = wrap(SUM_W'(front_reg) + SUM_W'(1));
    assign idx_back  = wrap(SUM_W'(front_reg) + SUM_W'(count_reg));
    assign idx_last  = wrap(SUM_W'(front_reg) + SUM_W'(count_reg) - SUM_W'(1));
    assign idx_pos   = wrap(SUM_W'(front_reg) + SUM_W'(pos_m1));

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        cmd_ctrl.op     = bdq_pkg::OP_NONE;
        cmd_ctrl.ok     = 1'b0;
        cmd_addr        = idx_back;
        case (req_type)
            bdq_pkg::REQ_PUSH_BACK:
            begin
                if (can_push)
                begin
                    cmd_ctrl.op = bdq_pkg::OP_WRITE;
                    cmd_ctrl.ok = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            bdq_pkg::REQ_PUSH_FRONT:
            begin
                cmd_addr = front_dec;
                if (can_push)
                begin
                    cmd_ctrl.op = bdq_pkg::OP_WRITE;
                    cmd_ctrl.ok = 1'b1;
                    front_next  = front_dec;
                    count_next  = count_reg + 1'b1;
                end
            end
            bdq_pkg::REQ_POP_FRONT:
            begin
                cmd_addr = front_reg;
                if (not_empty)
                begin
                    cmd_ctrl.op = bdq_pkg::OP_READ;
                    cmd_ctrl.ok = 1'b1;
                    front_next  = front_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            bdq_pkg::REQ_POP_BACK:
            begin
                cmd_addr = idx_last;
                if (not_empty)
                begin
                    cmd_ctrl.op = bdq_pkg::OP_READ;
                    cmd_ctrl.ok = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            bdq_pkg::REQ_READ_POS:
            begin
                cmd_addr = idx_pos;
                if (pos_ok)
                begin
                    cmd_ctrl.op = bdq_pkg::OP_READ;
                    cmd_ctrl.ok = 1'b1;
                end
            end
            bdq_pkg::REQ_COUNT:
            begin
                cmd_ctrl.ok = 1'b1;
            end
            default:
            begin
                cmd_ctrl.ok = 1'b0;
            end
        endcase
    end

    assign cmd_payload = req_payload;
    assign cmd_count   = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bdq_pkg::CAP_W'(bdq_pkg::CAP_RESET);
            front_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

### sv/bdq_back.sv
// Back end: runs store commands against the entry RAM and holds the result
// in an output register. Depends on bdq_pkg and bdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bdq_back #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_avail,
    output logic                            cmd_take,
    input  wire bdq_pkg::cmd_ctrl_t         cmd_ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]   cmd_addr,
    input  wire logic [DATA_W-1:0]          cmd_payload,
    input  wire logic [$clog2(DEPTH+1)-1:0] cmd_count,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output logic                            res_ok,
    output logic      [DATA_W-1:0]          res_data,
    output logic      [$clog2(DEPTH+1)-1:0] res_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic               p1_valid_reg;
    bdq_pkg::cmd_ctrl_t p1_ctrl_reg;
    logic [CNT_W-1:0]   p1_count_reg;
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_free, p1_move, issue;
    logic [DATA_W-1:0]  rdata;

    assign out_free = !out_valid_reg || res_ready;
    assign p1_move  = p1_valid_reg && out_free;
    assign issue    = cmd_avail && (!p1_valid_reg || out_free);
    assign cmd_take = issue;

    // read data stays put while the stage behind it is stalled: no read issues then
    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (issue && (cmd_ctrl.op == bdq_pkg::OP_WRITE)),
        .waddr (cmd_addr),
        .wdata (cmd_payload),
        .re    (issue && (cmd_ctrl.op == bdq_pkg::OP_READ)),
        .raddr (cmd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_ctrl_reg  <= cmd_ctrl;
            p1_count_reg <= cmd_count;
        end
        if (p1_move)
        begin
            out_ok_reg    <= p1_ctrl_reg.ok;
            out_data_reg  <= (p1_ctrl_reg.op == bdq_pkg::OP_READ) ? rdata : '0;
            out_count_reg <= p1_count_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_ok    = out_ok_reg;
    assign res_data  = out_data_reg;
    assign res_count = out_count_reg;

endmodule

`default_nettype wire

### sv/bounded_deque_with_indexed_read.sv
// Top level of the bounded deque with indexed read.
// Depends on bdq_pkg, bdq_front, bdq_queue, bdq_back (and bdq_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Contents
// s_*      in         s_tvalid/s_tready  request: s_tuser req_type, s_tdata payload, position
// m_*      out        m_tvalid/m_tready  result:  m_tuser ok, m_tdata data, count
// cfg_*    in         cfg_wen            capacity register write
//
// One request per clock sustained while m_tready stays high. An accepted request is
// written into the command queue, issued from there to the entry RAM (registered
// read), and moved into the output register that drives m_tvalid.
// Reset clears the front index, the count and capacity (to 256); RAM contents
// are left alone, since only entries that were pushed are ever read.
// A four-entry command queue sits between the front end and the RAM side, so
// a stalled result port holds off s_tready only once that queue is full.

module bounded_deque_with_indexed_read #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // capacity register
    input  wire logic                    cfg_wen,
    input  wire logic [8:0]              cfg_wdata,
    // request channel
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // payload (DATA_W), position (CNT_W), zero pad to bytes
    input  wire logic [((DATA_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type (3)
    input  wire logic [2:0]              s_tuser,
    // result channel
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // data (DATA_W), count (CNT_W), zero pad to bytes
    output logic      [((DATA_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata,
    // ok (1)
    output logic                         m_tuser
);

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int TDATA_W  = ((DATA_W + CNT_W + 7) / 8) * 8;
    localparam int CTRL_W   = $bits(bdq_pkg::cmd_ctrl_t);
    localparam int CMD_W    = CTRL_W + IDX_W + DATA_W + CNT_W;

    // front end -> command queue
    logic                 fe_valid;
    logic                 q_full;
    bdq_pkg::cmd_ctrl_t   fe_ctrl;
    logic [IDX_W-1:0]     fe_addr;
    logic [DATA_W-1:0]    fe_payload;
    logic [CNT_W-1:0]     fe_count;

    // command queue -> back end
    logic [CMD_W-1:0]     q_rd_data;
    logic                 q_not_empty;
    logic                 be_take;
    bdq_pkg::cmd_ctrl_t   be_ctrl;
    logic [IDX_W-1:0]     be_addr;
    logic [DATA_W-1:0]    be_payload;
    logic [CNT_W-1:0]     be_count;

    // result
    logic [DATA_W-1:0]    res_data;
    logic [CNT_W-1:0]     res_count;

    bdq_front #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .req_valid    (s_tvalid),
        .req_type     (s_tuser),
        .req_payload  (s_tdata[DATA_W-1:0]),
        .req_position (s_tdata[DATA_W +: CNT_W]),
        .req_ready    (s_tready),
        .cmd_valid    (fe_valid),
        .cmd_full     (q_full),
        .cmd_ctrl     (fe_ctrl),
        .cmd_addr     (fe_addr),
        .cmd_payload  (fe_payload),
        .cmd_count    (fe_count)
    );

    bdq_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fe_valid),
        .wr_data   ({fe_ctrl, fe_addr, fe_payload, fe_count}),
        .full      (q_full),
        .rd_en     (be_take),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    assign {be_ctrl, be_addr, be_payload, be_count} = q_rd_data;

    bdq_back #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (q_not_empty),
        .cmd_take    (be_take),
        .cmd_ctrl    (be_ctrl),
        .cmd_addr    (be_addr),
        .cmd_payload (be_payload),
        .cmd_count   (be_count),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_ok      (m_tuser),
        .res_data    (res_data),
        .res_count   (res_count)
    );

    // pack result: data in the low bits, count above, zeros up to a byte boundary
    assign m_tdata = TDATA_W'({res_count, res_data});

endmodule

`default_nettype wire
